// File: hw/rtl/isoasm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isoasm_pkg;

    // commands
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TEST   = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_REJECT    = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    // register indexes
    localparam logic [1:0] REG_FORMAT_128   = 2'd0;
    localparam logic [1:0] REG_MSG_TYPE_BCD = 2'd1;
    localparam logic [1:0] REG_MSG_TYPE     = 2'd2;

    localparam int          PADDR_W       = 4;
    localparam logic [31:0] MSG_TYPE_RST  = 32'h3030_3030;
    localparam int          NUM_SLOTS     = 129;
    localparam int          MAX_FIELD_64  = 64;
    localparam int          MAX_FIELD_128 = 128;
    localparam int          BITMAP_64     = 8;
    localparam int          BITMAP_128    = 16;
    localparam int          TYPE_ASCII    = 4;
    localparam int          TYPE_BCD      = 2;
    localparam int          LEN_SAT       = 16383;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] field_index;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        present;
        logic [7:0]  out_byte;
        logic        last_out;
        logic [13:0] message_length;
    } out_word_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic finish;
    } dp_cmd_t;

    function automatic logic in_range(logic [7:0] idx, logic f128);
        logic [7:0] top;
        top = f128 ? 8'(MAX_FIELD_128) : 8'(MAX_FIELD_64);
        return (idx >= 8'd2) && (idx <= top);
    endfunction

    function automatic logic [3:0] nibble_of(logic [7:0] c);
        logic [3:0] r;
        if (c inside {[8'h30:8'h39]})
            r = 4'(c - 8'h30);
        else if (c inside {[8'h41:8'h46]})
            r = 4'(c - 8'h41 + 8'd10);
        else if (c inside {[8'h61:8'h66]})
            r = 4'(c - 8'h61 + 8'd10);
        else
            r = c[3:0];
        return r;
    endfunction

    function automatic logic [7:0] type_byte(logic [31:0] mt, logic bcd, logic [1:0] p);
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] r;
        c0 = 8'(mt >> (5'd24 - {p[0], 4'b0}));
        c1 = 8'(mt >> (5'd16 - {p[0], 4'b0}));
        if (bcd)
            r = {nibble_of(c0), nibble_of(c1)};
        else
            r = 8'(mt >> (5'd24 - {p, 3'b0}));
        return r;
    endfunction

    function automatic logic [7:0] bitmap_byte(logic [128:0] v, logic [3:0] p);
        logic [7:0] r;
        r = '0;
        for (int k = 0; k < 8; k++)
            r[7-k] = v[8*int'(p) + k + 1];
        return r;
    endfunction

    // lowest present field above thr
    function automatic logic [7:0] first_above(logic [128:0] v, logic [7:0] thr);
        logic [7:0] r;
        r = '0;
        for (int i = 128; i >= 2; i--)
            if (v[i] && (i > int'(thr)))
                r = 8'(i);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/isoasm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface isoasm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] field_index;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, command, field_index, data_byte, last_byte, input ready);
    modport sink   (input valid, command, field_index, data_byte, last_byte, output ready);
endinterface

interface isoasm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        present;
    logic [7:0]  out_byte;
    logic        last_out;
    logic [13:0] message_length;

    modport source (output valid, status, present, out_byte, last_out, message_length,
                    input ready);
    modport sink   (input valid, status, present, out_byte, last_out, message_length,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/isoasm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module isoasm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

// File: hw/rtl/isoasm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module isoasm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output isoasm_pkg::dp_cmd_t     ctl
);
    import isoasm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       finish, accept;

    assign finish    = (state_reg == S_RESP) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE) || finish;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign ctl.latch  = accept;
    assign ctl.exec   = (state_reg == S_EXEC);
    assign ctl.finish = finish;

    always_comb
    begin
        out_valid_next = finish || (out_valid_reg && !out_ready);
        case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_RESP;
            S_RESP:  state_next = finish ? (accept ? S_EXEC : S_IDLE) : S_RESP;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

`default_nettype wire

// File: hw/rtl/isoasm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module isoasm_dp #(
    parameter int FIELD_BYTES = 64,
    parameter int MSG_BYTES   = 8192
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  isoasm_pkg::dp_cmd_t       ctl,
    input  isoasm_pkg::in_word_t      in_word,
    output isoasm_pkg::out_word_t     res,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_wdata,
    output logic      [31:0]          cfg_rdata
);
    import isoasm_pkg::*;

    localparam int LEN_W = $clog2(FIELD_BYTES + 1);
    localparam int SUM_W = $clog2(127 * FIELD_BYTES + 1);
    localparam int TOT_W = $clog2(127 * FIELD_BYTES + 21);
    localparam int POS_W = $clog2(MSG_BYTES + 1);
    localparam int DEPTH = NUM_SLOTS * FIELD_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic              fmt_reg, fmt_next;
    logic              bcd_reg, bcd_next;
    logic [31:0]       mtype_reg, mtype_next;
    in_word_t          item_reg;
    logic [128:0]      present_reg, present_next;
    logic [SUM_W-1:0]  sum_lo_reg, sum_lo_next;
    logic [SUM_W-1:0]  sum_hi_reg, sum_hi_next;
    logic              act_reg, act_next;
    logic [7:0]        aidx_reg, aidx_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              err_reg, err_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        fcur_reg, fcur_next;
    logic [LEN_W-1:0]  off_reg, off_next;
    out_word_t         res_reg, res_next;

    logic [7:0]        idx;
    logic [7:0]        a_idx;
    logic [LEN_W-1:0]  a_cnt, cnt1;
    logic              a_err0, ovf, err1, commit, rm_ok;
    logic [128:0]      vis;
    logic              any;
    logic [2:0]        mt_len;
    logic [4:0]        head;
    logic [TOT_W-1:0]  total;
    logic              fst_we, len_we;
    logic [AW-1:0]     fst_waddr, fst_raddr;
    logic [7:0]        fst_rdata;
    logic [7:0]        len_raddr;
    logic [LEN_W-1:0]  len_rdata;
    logic [7:0]        first_f, next_f;
    logic [3:0]        bm_p;
    logic              lo_hit;

    // add sequence view for the latched word
    assign idx    = item_reg.field_index;
    assign a_idx  = act_reg ? aidx_reg : idx;
    assign a_cnt  = act_reg ? cnt_reg : '0;
    assign a_err0 = act_reg ? err_reg : !(in_range(idx, fmt_reg) && !present_reg[idx]);
    assign ovf    = (a_cnt == LEN_W'(FIELD_BYTES));
    assign err1   = a_err0 || ovf;
    assign cnt1   = ovf ? a_cnt : a_cnt + 1'b1;
    assign commit = item_reg.last_byte && !err1 && in_range(a_idx, fmt_reg)
                    && !present_reg[a_idx];
    assign rm_ok  = in_range(idx, fmt_reg) && present_reg[idx];

    // bitmap as seen by readout
    always_comb
    begin
        vis    = '0;
        vis[1] = fmt_reg;
        for (int i = 2; i <= 128; i++)
            vis[i] = present_reg[i] && (fmt_reg || (i <= MAX_FIELD_64));
    end

    assign any    = |vis[128:2];
    assign mt_len = bcd_reg ? 3'(TYPE_BCD) : 3'(TYPE_ASCII);
    assign head   = 5'(mt_len) + (fmt_reg ? 5'(BITMAP_128) : 5'(BITMAP_64));
    assign total  = TOT_W'(head) + TOT_W'(sum_lo_reg)
                    + (fmt_reg ? TOT_W'(sum_hi_reg) : TOT_W'(0));
    assign first_f = first_above(vis, 8'd1);
    assign next_f  = first_above(vis, fcur_reg);
    assign bm_p    = 4'(pos_reg - POS_W'(mt_len));
    assign lo_hit  = (32'(pos_reg) + 32'd1) == 32'(total);

    // field store: write on add, read on readout
    assign fst_we    = ctl.exec && (item_reg.command == CMD_ADD) && !err1;
    assign fst_waddr = AW'(32'(a_idx) * FIELD_BYTES + 32'(a_cnt));
    assign fst_raddr = AW'(32'(fcur_reg) * FIELD_BYTES + 32'(off_reg));
    assign len_we    = ctl.finish && (item_reg.command == CMD_ADD) && commit;
    assign len_raddr = (item_reg.command == CMD_REMOVE) ? idx : fcur_reg;

    isoasm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_field_ram (
        .clk   (clk),
        .we    (fst_we),
        .waddr (fst_waddr),
        .wdata (item_reg.data_byte),
        .re    (ctl.exec),
        .raddr (fst_raddr),
        .rdata (fst_rdata)
    );

    isoasm_ram #(.WIDTH(LEN_W), .DEPTH(NUM_SLOTS)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (a_idx),
        .wdata (cnt1),
        .re    (ctl.exec),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    always_comb
    begin
        fmt_next     = fmt_reg;
        bcd_next     = bcd_reg;
        mtype_next   = mtype_reg;
        present_next = present_reg;
        sum_lo_next  = sum_lo_reg;
        sum_hi_next  = sum_hi_reg;
        act_next     = act_reg;
        aidx_next    = aidx_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        pos_next     = pos_reg;
        fcur_next    = fcur_reg;
        off_next     = off_reg;
        res_next     = res_reg;

        if (ctl.finish)
        begin
            res_next = '0;
            case (item_reg.command)
                CMD_ADD:
                begin
                    if (item_reg.last_byte)
                    begin
                        act_next  = 1'b0;
                        aidx_next = '0;
                        cnt_next  = '0;
                        err_next  = 1'b0;
                        if (commit)
                        begin
                            present_next[a_idx] = 1'b1;
                            if (a_idx > 8'(MAX_FIELD_64))
                                sum_hi_next = sum_hi_reg + SUM_W'(cnt1);
                            else
                                sum_lo_next = sum_lo_reg + SUM_W'(cnt1);
                            pos_next = '0;
                        end
                        else
                            res_next.status = ST_REJECT;
                    end
                    else
                    begin
                        act_next  = 1'b1;
                        aidx_next = a_idx;
                        cnt_next  = cnt1;
                        err_next  = err1;
                        if (err1)
                            res_next.status = ST_REJECT;
                    end
                end
                CMD_REMOVE:
                begin
                    if (rm_ok)
                    begin
                        present_next[idx] = 1'b0;
                        if (idx > 8'(MAX_FIELD_64))
                            sum_hi_next = sum_hi_reg - SUM_W'(len_rdata);
                        else
                            sum_lo_next = sum_lo_reg - SUM_W'(len_rdata);
                        pos_next = '0;
                    end
                    else
                        res_next.status = ST_REJECT;
                end
                CMD_TEST:
                begin
                    res_next.present = rm_ok;
                end
                CMD_READ:
                begin
                    if (!any)
                        res_next.status = ST_EMPTY;
                    else
                    begin
                        res_next.message_length = (32'(total) > 32'(LEN_SAT)) ?
                                                  14'(LEN_SAT) : 14'(total);
                        if (32'(total) > 32'(MSG_BYTES))
                            res_next.status = ST_TOO_LARGE;
                        else
                        begin
                            if (32'(pos_reg) < 32'(mt_len))
                                res_next.out_byte = type_byte(mtype_reg, bcd_reg,
                                                              pos_reg[1:0]);
                            else if (32'(pos_reg) < 32'(head))
                                res_next.out_byte = bitmap_byte(vis, bm_p);
                            else
                                res_next.out_byte = fst_rdata;

                            if (lo_hit)
                            begin
                                res_next.last_out = 1'b1;
                                pos_next          = '0;
                            end
                            else
                            begin
                                pos_next = pos_reg + 1'b1;
                                if ((32'(pos_reg) + 32'd1) == 32'(head))
                                begin
                                    fcur_next = first_f;
                                    off_next  = '0;
                                end
                                else if (32'(pos_reg) >= 32'(head))
                                begin
                                    if ((32'(off_reg) + 32'd1) == 32'(len_rdata))
                                    begin
                                        fcur_next = next_f;
                                        off_next  = '0;
                                    end
                                    else
                                        off_next = off_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_FORMAT_128:
                begin
                    fmt_next = cfg_wdata[0];
                    pos_next = '0;
                end
                REG_MSG_TYPE_BCD:
                begin
                    bcd_next = cfg_wdata[0];
                    pos_next = '0;
                end
                REG_MSG_TYPE:
                begin
                    mtype_next = cfg_wdata;
                    pos_next   = '0;
                end
                default:
                begin
                    pos_next = pos_next;
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_FORMAT_128:   cfg_rdata = {31'b0, fmt_reg};
            REG_MSG_TYPE_BCD: cfg_rdata = {31'b0, bcd_reg};
            REG_MSG_TYPE:     cfg_rdata = mtype_reg;
            default:          cfg_rdata = '0;
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg     <= 1'b0;
            bcd_reg     <= 1'b0;
            mtype_reg   <= MSG_TYPE_RST;
            present_reg <= '0;
            sum_lo_reg  <= '0;
            sum_hi_reg  <= '0;
            act_reg     <= 1'b0;
            aidx_reg    <= '0;
            cnt_reg     <= '0;
            err_reg     <= 1'b0;
            pos_reg     <= '0;
            fcur_reg    <= '0;
            off_reg     <= '0;
        end
        else
        begin
            fmt_reg     <= fmt_next;
            bcd_reg     <= bcd_next;
            mtype_reg   <= mtype_next;
            present_reg <= present_next;
            sum_lo_reg  <= sum_lo_next;
            sum_hi_reg  <= sum_hi_next;
            act_reg     <= act_next;
            aidx_reg    <= aidx_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            pos_reg     <= pos_next;
            fcur_reg    <= fcur_next;
            off_reg     <= off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
            item_reg <= in_word;
        res_reg <= res_next;
    end
endmodule

`default_nettype wire

// File: hw/rtl/iso8583_message_assembler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// order: an accepted word is latched, the field ram read is registered in the
//   execute state, and the result word is registered as the respond state ends;
//   a new word is not accepted before the previous result is registered
// reset: rst_n asynchronous active low; clears the bitmap, lengths sums, add
//   sequence, read position and registers; field data is not cleared

module iso8583_message_assembler_core #(
    parameter int FIELD_BYTES = 64,
    parameter int MSG_BYTES   = 8192
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    isoasm_in_if.sink                             cmd_in,
    isoasm_out_if.source                          rsp_out,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [isoasm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready
);
    import isoasm_pkg::*;

    dp_cmd_t   ctl;
    in_word_t  in_word;
    out_word_t res;
    logic      cfg_we;

    // apb: zero wait states, write lands on the access cycle
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    // pack the incoming word
    assign in_word.command     = cmd_in.command;
    assign in_word.field_index = cmd_in.field_index;
    assign in_word.data_byte   = cmd_in.data_byte;
    assign in_word.last_byte   = cmd_in.last_byte;

    // sequencer: accept, execute with ram access, respond
    isoasm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_in.valid),
        .in_ready  (cmd_in.ready),
        .out_valid (rsp_out.valid),
        .out_ready (rsp_out.ready),
        .ctl       (ctl)
    );

    // field table, length sums, readout cursor and config registers
    isoasm_dp #(
        .FIELD_BYTES (FIELD_BYTES),
        .MSG_BYTES   (MSG_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_word   (in_word),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (paddr[3:2]),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata)
    );

    // result word
    assign rsp_out.status         = res.status;
    assign rsp_out.present        = res.present;
    assign rsp_out.out_byte       = res.out_byte;
    assign rsp_out.last_out       = res.last_out;
    assign rsp_out.message_length = res.message_length;
endmodule

`default_nettype wire

// File: hw/rtl/isoasm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module isoasm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic        present,
    input wire logic [7:0]  out_byte,
    input wire logic        last_out,
    input wire logic [13:0] message_length
);
    import isoasm_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> (message_length == 14'd0) && !last_out)
        else $error("empty message with length");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (last_out || present) |-> (status == ST_OK))
        else $error("flag set on failed word");

    a_large: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_TOO_LARGE) |->
            (out_byte == 8'd0) && (message_length != 14'd0) && !last_out)
        else $error("oversize word with data");
endmodule

bind iso8583_message_assembler_core isoasm_checker u_isoasm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (rsp_out.valid),
    .out_ready      (rsp_out.ready),
    .status         (rsp_out.status),
    .present        (rsp_out.present),
    .out_byte       (rsp_out.out_byte),
    .last_out       (rsp_out.last_out),
    .message_length (rsp_out.message_length)
);

`default_nettype wire

// File: tb/iso8583_message_assembler_core_tb.sv
`timescale 1ns / 1ps

module iso8583_message_assembler_core_tb;
    import isoasm_pkg::*;

    localparam int FLD_BYTES = 64;
    localparam int MSG_MAX   = 8192;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    isoasm_in_if  cmd_in ();
    isoasm_out_if rsp_out ();

    iso8583_message_assembler_core #(.FIELD_BYTES(FLD_BYTES), .MSG_BYTES(MSG_MAX)) dut (
        .clk(clk), .rst_n(rst_n), .cmd_in(cmd_in), .rsp_out(rsp_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow of the assembler: field table, add sequence, readout position
    class msg_scoreboard;
        bit        fmt128;
        bit        bcd;
        bit [31:0] mtype;
        bit        pres[129];
        int        flen[129];
        bit [7:0]  store[129][FLD_BYTES];
        bit        adding;
        int        add_idx;
        int        add_cnt;
        bit        add_err;
        int        rd_pos;
        out_word_t pending[$];
        int        errors;

        function void clear();
            fmt128 = 0; bcd = 0; mtype = MSG_TYPE_RST;
            foreach (pres[i]) begin
                pres[i] = 0;
                flen[i] = 0;
            end
            adding = 0; add_idx = 0; add_cnt = 0; add_err = 0; rd_pos = 0;
            pending.delete();
            errors = 0;
        endfunction

        function int top_fld();
            return fmt128 ? 128 : 64;
        endfunction

        function bit addable(int i);
            return i >= 2 && i <= top_fld() && !pres[i];
        endfunction

        function void set_reg(int r, bit [31:0] v);
            if (r == REG_FORMAT_128) fmt128 = v[0];
            else if (r == REG_MSG_TYPE_BCD) bcd = v[0];
            else mtype = v;
            rd_pos = 0;
        endfunction

        function bit [3:0] hexval(bit [7:0] c);
            if (c >= "0" && c <= "9") return 4'(c - "0");
            if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
            if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
            return c[3:0];
        endfunction

        function bit [7:0] tchar(int k);
            return mtype[31 - 8*k -: 8];
        endfunction

        // byte p of the packed message
        function bit [7:0] packed_byte(int p);
            int mt, bm;
            bit [7:0] v;
            mt = bcd ? 2 : 4;
            bm = fmt128 ? 16 : 8;
            if (p < mt)
                return bcd ? {hexval(tchar(2*p)), hexval(tchar(2*p+1))} : tchar(p);
            p -= mt;
            if (p < bm) begin
                v = 0;
                for (int k = 0; k < 8; k++) begin
                    int f;
                    f = 8*p + k + 1;
                    if (f == 1 ? fmt128 : (f <= top_fld() && pres[f])) v[7-k] = 1;
                end
                return v;
            end
            p -= bm;
            for (int f = 2; f <= top_fld(); f++) begin
                if (!pres[f]) continue;
                if (p < flen[f]) return store[f][p];
                p -= flen[f];
            end
            return 0;
        endfunction

        function void note_word(in_word_t w);
            out_word_t r;
            int i;
            r = '0;
            i = w.field_index;
            case (w.command)
                CMD_ADD: begin
                    if (!adding) begin
                        adding = 1; add_idx = i; add_cnt = 0; add_err = !addable(i);
                    end
                    if (add_cnt >= FLD_BYTES) add_err = 1;
                    else begin
                        if (!add_err) store[add_idx][add_cnt] = w.data_byte;
                        add_cnt++;
                    end
                    if (w.last_byte) begin
                        if (!add_err && addable(add_idx)) begin
                            pres[add_idx] = 1; flen[add_idx] = add_cnt; rd_pos = 0;
                        end else r.status = ST_REJECT;
                        adding = 0; add_idx = 0; add_cnt = 0; add_err = 0;
                    end else if (add_err) r.status = ST_REJECT;
                end
                CMD_REMOVE: begin
                    if (i >= 2 && i <= top_fld() && pres[i]) begin
                        pres[i] = 0; flen[i] = 0; rd_pos = 0;
                    end else r.status = ST_REJECT;
                end
                CMD_TEST: begin
                    if (i >= 2 && i <= top_fld()) r.present = pres[i];
                end
                default: begin
                    int total;
                    bit any;
                    total = (bcd ? 2 : 4) + (fmt128 ? 16 : 8);
                    any = 0;
                    for (int f = 2; f <= top_fld(); f++)
                        if (pres[f]) begin
                            any = 1;
                            total += flen[f];
                        end
                    if (!any) r.status = ST_EMPTY;
                    else begin
                        r.message_length = 14'(total > LEN_SAT ? LEN_SAT : total);
                        if (total > MSG_MAX) r.status = ST_TOO_LARGE;
                        else begin
                            if (rd_pos >= total) rd_pos = 0;
                            r.out_byte = packed_byte(rd_pos);
                            if (rd_pos + 1 == total) begin
                                r.last_out = 1; rd_pos = 0;
                            end else rd_pos++;
                        end
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_word(out_word_t got);
            out_word_t exp_w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word: got %p", $time, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.status !== exp_w.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp_w.status, got.status);
                errors++;
            end
            if (got.present !== exp_w.present) begin
                $display("%0t: present exp %0d got %0d", $time, exp_w.present, got.present);
                errors++;
            end
            if (got.out_byte !== exp_w.out_byte) begin
                $display("%0t: out_byte exp %h got %h", $time, exp_w.out_byte, got.out_byte);
                errors++;
            end
            if (got.last_out !== exp_w.last_out) begin
                $display("%0t: last_out exp %0d got %0d", $time, exp_w.last_out, got.last_out);
                errors++;
            end
            if (got.message_length !== exp_w.message_length) begin
                $display("%0t: message_length exp %0d got %0d", $time,
                         exp_w.message_length, got.message_length);
                errors++;
            end
        endfunction
    endclass

    msg_scoreboard sb;
    int cycles;
    int burst_left;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // monitors: sample just after the edge using values of the edge
    always @(posedge clk) begin
        if (rst_n && cmd_in.valid && cmd_in.ready)
            sb.note_word('{cmd_in.command, cmd_in.field_index, cmd_in.data_byte,
                           cmd_in.last_byte});
        if (rst_n && rsp_out.valid && rsp_out.ready)
            sb.check_word('{rsp_out.status, rsp_out.present, rsp_out.out_byte,
                            rsp_out.last_out, rsp_out.message_length});
    end

    // receiver stall pattern: long free runs alternating with random stalls
    always @(posedge clk) begin
        int ph;
        ph = (cycles / 300) % 3;
        if (!rst_n) rsp_out.ready <= 1'b0;
        else if (ph == 0) rsp_out.ready <= 1'b1;
        else if (ph == 1) rsp_out.ready <= ($urandom_range(0, 3) != 0);
        else rsp_out.ready <= ($urandom_range(0, 2) == 0);
    end

    // send one word; words come in bursts with random gaps between, valid stays up inside a burst
    task automatic send_word(logic [1:0] c, logic [7:0] i, logic [7:0] d, logic l);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                cmd_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        cmd_in.valid       <= 1'b1;
        cmd_in.command     <= c;
        cmd_in.field_index <= i;
        cmd_in.data_byte   <= d;
        cmd_in.last_byte   <= l;
        @(posedge clk);
        while (!cmd_in.ready) @(posedge clk);
    endtask

    // add a whole field of n bytes with random content
    task automatic add_field(int idx, int n);
        for (int k = 0; k < n; k++)
            send_word(CMD_ADD, 8'(idx), 8'($urandom_range(0, 255)), k == n - 1);
    endtask

    task automatic drain();
        cmd_in.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(int r, logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= PADDR_W'(4 * r); pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(r, v);
    endtask

    // send between 1 and 140 read words, which may stop mid message or run into the next pass
    task automatic read_all();
        int n;
        n = $urandom_range(1, 140);
        repeat (n) send_word(CMD_READ, 8'd0, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
    endtask

    task automatic random_phase(int items);
        int done;
        int top;
        done = 0;
        while (done < items) begin
            int pick, n, idx;
            top = sb.fmt128 ? 128 : 64;
            pick = $urandom_range(0, 99);
            idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(2, top);
            if (pick < 35) begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70)
                                                 : $urandom_range(1, 6);
                add_field(idx, n);
                done += n;
            end else if (pick < 45) begin
                send_word(CMD_REMOVE, 8'(idx), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                done++;
            end else if (pick < 55) begin
                send_word(CMD_TEST, 8'(idx), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                done++;
            end else if (pick < 60) begin
                // interleaved command inside an add sequence
                send_word(CMD_ADD, 8'(idx), 8'($urandom_range(0, 255)), 1'b0);
                send_word(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)), 8'h00, 1'b0);
                send_word(CMD_ADD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'b1);
                done += 3;
            end else begin
                n = $urandom_range(1, 30);
                repeat (n) send_word(CMD_READ, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                done += n;
            end
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        burst_left = 0;
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        cmd_in.valid = 0; cmd_in.command = CMD_ADD; cmd_in.field_index = 0;
        cmd_in.data_byte = 0; cmd_in.last_byte = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty read, range edges, duplicate, oversize field
        send_word(CMD_READ, 8'hff, 8'hff, 1);
        send_word(CMD_TEST, 0, 0, 0);
        send_word(CMD_REMOVE, 2, 0, 0);
        add_field(1, 1);
        add_field(65, 2);
        add_field(2, 1);
        add_field(64, 3);
        add_field(2, 1);
        add_field(10, 66);
        send_word(CMD_TEST, 2, 0, 0);
        send_word(CMD_TEST, 255, 0, 0);
        read_all();
        drain();

        // 128-bit bitmap with BCD type and non-hex characters
        reg_write(REG_FORMAT_128, 1);
        reg_write(REG_MSG_TYPE_BCD, 1);
        reg_write(REG_MSG_TYPE, 32'h3aF0_7a9e);
        add_field(128, 2);
        add_field(100, 64);
        read_all();
        drain();
        // back to 64: high fields hidden
        reg_write(REG_FORMAT_128, 0);
        send_word(CMD_TEST, 128, 0, 0);
        send_word(CMD_REMOVE, 100, 0, 0);
        read_all();
        send_word(CMD_REMOVE, 64, 0, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            reg_write(REG_FORMAT_128, ph[0]);
            reg_write(REG_MSG_TYPE_BCD, ph[1]);
            reg_write(REG_MSG_TYPE, ph == 3 ? 32'hffff_ffff : (ph == 5 ? 32'h0 : $urandom));
            random_phase(165);
            drain();
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/isoasm_pkg.sv
hw/rtl/isoasm_if.sv
hw/rtl/isoasm_ram.sv
hw/rtl/isoasm_ctrl.sv
hw/rtl/isoasm_dp.sv
hw/rtl/iso8583_message_assembler_core.sv
hw/rtl/isoasm_checker.sv
tb/iso8583_message_assembler_core_tb.sv
